/* hw/rtl/lsdh_pkg.sv */
// ----------------------------------------------------------------------------
// lsdh_pkg
// Shared types and constants for the LRU stack distance histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lsdh_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int COUNT_BITS_DEF  = 48;

    localparam int NUM_BINS  = 256;
    localparam int BIN_W     = 8;
    localparam int TAG_W     = 64;
    localparam int OUT_W     = 48;
    localparam int LSL_W     = 4;
    localparam int LIMIT_W   = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;
    localparam int KIND_W    = 2;

    localparam logic [LSL_W-1:0]   LSL_RESET   = 4'd6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_SIZE_LOG2 = 1'b0,
        REG_DISTANCE_LIMIT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        CMD_ACCESS = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSTR = 2'd0,
        KIND_DATA  = 2'd1
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_RES,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* hw/rtl/lru_stack_distance_histogram_unit.sv */
// ----------------------------------------------------------------------------
// lru_stack_distance_histogram_unit
// LRU stack distance reuse histogram over a chain of tag cells.
// ----------------------------------------------------------------------------
// An access (command 0, kind instruction or data) goes through these steps
// from start to the next possible start: key compare across all cells, hit
// encode and histogram read, then the stack shift and histogram write. A read
// command or an ignored kind passes through the registered histogram RAM read.
// Each result is shown for one cycle on o_result_strobe and cannot be held
// off. Configuration writes are always ready; write them only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_stack_distance_histogram_unit
    import lsdh_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_command,
    input  wire logic [TAG_W-1:0]     i_address,
    input  wire logic [KIND_W-1:0]    i_access_kind,
    input  wire logic [BIN_W-1:0]     i_bin_index,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                      o_result_strobe,
    output logic                      o_hit,
    output logic      [BIN_W-1:0]     o_distance,
    output logic                      o_evicted,
    output logic      [TAG_W-1:0]     o_evicted_tag,
    output logic      [OUT_W-1:0]     o_instr_bin_count,
    output logic      [OUT_W-1:0]     o_dhist_count,
    output logic      [OUT_W-1:0]     o_ref_total,
    output logic      [OUT_W-1:0]     o_dref_total,
    output logic      [OUT_W-1:0]     o_pruned_count
);

    localparam int IW  = $clog2(STACK_DEPTH);
    localparam int FW  = $clog2(STACK_DEPTH + 1);
    localparam int PW  = (IW > BIN_W) ? IW : BIN_W;
    localparam int LCW = (FW > LIMIT_W) ? FW : LIMIT_W;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    t_state r_state, n_state;

    logic                  w_accept;
    logic                  w_ignored;
    logic [LSL_W-1:0]      r_lsl;
    logic [LIMIT_W-1:0]    r_limit;
    logic [TAG_W-1:0]      r_key;
    logic                  r_is_data;
    logic                  r_rd_bins;
    logic [FW-1:0]         r_fill;
    logic [FW-1:0]         w_lim;

    t_cell_ctrl            w_ctrl;
    logic [TAG_W-1:0]      w_tag  [STACK_DEPTH];
    logic [TAG_W-1:0]      w_tail [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] w_match;
    logic [IW-1:0]         w_pos;
    logic [TAG_W-1:0]      w_evtag;
    logic                  w_hit;
    logic                  w_evict;
    logic [PW-1:0]         w_pos_ext;
    logic [BIN_W-1:0]      w_bin;

    logic                  r_hit;
    logic                  r_evict;
    logic [TAG_W-1:0]      r_evtag;
    logic [IW-1:0]         r_span;
    logic [BIN_W-1:0]      r_bin;

    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_data;
    logic [COUNT_BITS-1:0] r_prune;

    logic [BIN_W-1:0]      w_raddr;
    logic [COUNT_BITS-1:0] w_irdata;
    logic [COUNT_BITS-1:0] w_drdata;
    logic [NUM_BINS-1:0]   r_ivld;
    logic [NUM_BINS-1:0]   r_dvld;
    logic                  r_ivld_q;
    logic                  r_dvld_q;
    logic [COUNT_BITS-1:0] w_icnt;
    logic [COUNT_BITS-1:0] w_dcnt;
    logic [COUNT_BITS-1:0] w_sel;
    logic [COUNT_BITS-1:0] w_inc;
    logic                  w_iwe;
    logic                  w_dwe;

    assign busy        = (r_state != ST_IDLE);
    assign w_accept    = start && !busy;
    assign w_ignored   = (i_access_kind != KIND_INSTR) && (i_access_kind != KIND_DATA);
    assign o_cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsl   <= LSL_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LINE_SIZE_LOG2: r_lsl   <= i_cfg_data[LSL_W-1:0];
                REG_DISTANCE_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_READ || w_ignored) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_CMP;
                    end
                end
            end
            ST_READ: n_state = ST_IDLE;
            ST_CMP:  n_state = ST_RES;
            ST_RES:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctrl.cmp_en   = 1'b0;
        w_ctrl.shift_en = 1'b0;
        w_raddr         = w_bin;
        w_iwe           = 1'b0;
        w_dwe           = 1'b0;
        case (r_state)
            ST_IDLE: w_raddr = i_bin_index;
            ST_CMP:  w_ctrl.cmp_en = 1'b1;
            ST_UPD: begin
                w_ctrl.shift_en = 1'b1;
                w_iwe           = r_hit && !r_is_data;
                w_dwe           = r_hit && r_is_data;
            end
            default: ;
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key     <= i_address >> r_lsl;
            r_is_data <= (i_access_kind == KIND_DATA);
            r_rd_bins <= (i_command == CMD_READ);
        end
    end

    // tag stack
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        lsdh_cell #(
            .DEPTH    (STACK_DEPTH),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_key      (r_key),
            .i_prev_tag ((g == 0) ? r_key : w_tag[(g == 0) ? 0 : g - 1]),
            .i_fill     (r_fill),
            .i_span     (r_span),
            .o_tag      (w_tag[g]),
            .o_match    (w_match[g]),
            .o_tail_tag (w_tail[g])
        );
    end

    always_comb begin
        w_pos   = '0;
        w_evtag = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (w_match[i]) begin
                w_pos = w_pos | IW'(i);
            end
            w_evtag = w_evtag | w_tail[i];
        end
    end

    assign w_hit     = |w_match;
    assign w_lim     = (r_limit == '0 || LCW'(r_limit) > LCW'(STACK_DEPTH)) ?
                       FW'(STACK_DEPTH) : FW'(r_limit);
    assign w_evict   = !w_hit && (r_fill >= w_lim);
    assign w_pos_ext = PW'(w_pos);
    assign w_bin     = (w_pos_ext > PW'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
                                                       : w_pos_ext[BIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RES) begin
            r_hit   <= w_hit;
            r_evict <= w_evict;
            r_evtag <= w_evict ? w_evtag : '0;
            r_bin   <= w_bin;
            if (w_hit) begin
                r_span <= w_pos;
            end else if (w_evict) begin
                r_span <= IW'(r_fill - 1'b1);
            end else begin
                r_span <= IW'(r_fill);
            end
        end
    end

    // fill and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_total <= '0;
            r_data  <= '0;
            r_prune <= '0;
        end else begin
            if (r_state == ST_RES) begin
                if (r_total != CMAX) begin
                    r_total <= r_total + 1'b1;
                end
                if (r_is_data && r_data != CMAX) begin
                    r_data <= r_data + 1'b1;
                end
                if (w_evict && r_prune != CMAX) begin
                    r_prune <= r_prune + 1'b1;
                end
            end
            if (r_state == ST_UPD && !r_hit && !r_evict) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // histograms
    lsdh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_instr_hist (
        .i_clk   (i_clk),
        .i_we    (w_iwe),
        .i_waddr (r_bin),
        .i_wdata (w_inc),
        .i_raddr (w_raddr),
        .o_rdata (w_irdata)
    );

    lsdh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_data_hist (
        .i_clk   (i_clk),
        .i_we    (w_dwe),
        .i_waddr (r_bin),
        .i_wdata (w_inc),
        .i_raddr (w_raddr),
        .o_rdata (w_drdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivld <= '0;
            r_dvld <= '0;
        end else begin
            if (w_iwe) begin
                r_ivld[r_bin] <= 1'b1;
            end
            if (w_dwe) begin
                r_dvld[r_bin] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ivld_q <= r_ivld[w_raddr];
        r_dvld_q <= r_dvld[w_raddr];
    end

    assign w_icnt = r_ivld_q ? w_irdata : '0;
    assign w_dcnt = r_dvld_q ? w_drdata : '0;
    assign w_sel  = r_is_data ? w_dcnt : w_icnt;
    assign w_inc  = (w_sel == CMAX) ? w_sel : w_sel + 1'b1;

    // result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= (r_state == ST_READ) || (r_state == ST_UPD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            o_hit             <= 1'b0;
            o_distance        <= '0;
            o_evicted         <= 1'b0;
            o_evicted_tag     <= '0;
            o_instr_bin_count <= r_rd_bins ? OUT_W'(w_icnt) : '0;
            o_dhist_count     <= r_rd_bins ? OUT_W'(w_dcnt) : '0;
            o_ref_total       <= OUT_W'(r_total);
            o_dref_total      <= OUT_W'(r_data);
            o_pruned_count    <= OUT_W'(r_prune);
        end else if (r_state == ST_UPD) begin
            o_hit             <= r_hit;
            o_distance        <= r_hit ? r_bin : '0;
            o_evicted         <= r_evict;
            o_evicted_tag     <= r_evtag;
            o_instr_bin_count <= '0;
            o_dhist_count     <= '0;
            o_ref_total       <= OUT_W'(r_total);
            o_dref_total      <= OUT_W'(r_data);
            o_pruned_count    <= OUT_W'(r_prune);
        end
    end

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(STACK_DEPTH))
        else $error("stack fill above depth");

    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RES) |-> $onehot0(w_match))
        else $error("tag present in more than one cell");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_strobe) |-> $past(r_state == ST_READ || r_state == ST_UPD))
        else $error("result strobe without finished request");

    a_hit_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !(o_hit && o_evicted))
        else $error("hit and eviction on one request");

endmodule

`default_nettype wire

/* hw/rtl/lsdh_ram.sv */
// ----------------------------------------------------------------------------
// lsdh_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/lsdh_cell.sv */
// ----------------------------------------------------------------------------
// lsdh_cell
// One LRU stack slot: holds a tag, compares it with the key and takes the
// tag of its upper neighbor on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdh_cell
    import lsdh_pkg::*;
#(
    parameter int DEPTH    = STACK_DEPTH_DEF,
    parameter int CELL_IDX = 0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cell_ctrl                 i_ctrl,
    input  wire logic [TAG_W-1:0]           i_key,
    input  wire logic [TAG_W-1:0]           i_prev_tag,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_fill,
    input  wire logic [$clog2(DEPTH)-1:0]   i_span,
    output logic      [TAG_W-1:0]           o_tag,
    output logic                            o_match,
    output logic      [TAG_W-1:0]           o_tail_tag
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic w_valid;
    logic w_tail;
    logic w_shift;

    assign w_valid    = FW'(CELL_IDX) < i_fill;
    assign w_tail     = FW'(CELL_IDX + 1) == i_fill;
    assign w_shift    = i_ctrl.shift_en && (IW'(CELL_IDX) <= i_span);
    assign o_tail_tag = w_tail ? o_tag : '0;

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            o_tag <= i_prev_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_match <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            o_match <= w_valid && (o_tag == i_key);
        end
    end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for lru_stack_distance_histogram_unit. A driver feeds access and
// read requests from a queue with random idle gaps. A monitor predicts each
// accepted request against a behavioral copy of the tag stack, histograms and
// counters, and checks every result strobe field by field. Phases step
// through line sizes and distance limits, including a full stack, a limit
// lowered below the fill, and a limit above the stack depth.
// ----------------------------------------------------------------------------
module tb_top;
    import lsdh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    typedef struct packed {
        t_cmd               cmd;
        logic [TAG_W-1:0]   addr;
        logic [KIND_W-1:0]  kind;
        logic [BIN_W-1:0]   bin;
    } t_access_req;

    typedef struct packed {
        logic               hit;
        logic [BIN_W-1:0]   distance;
        logic               evicted;
        logic [TAG_W-1:0]   evicted_tag;
        logic [OUT_W-1:0]   instr_bin;
        logic [OUT_W-1:0]   data_bin;
        logic [OUT_W-1:0]   ref_total;
        logic [OUT_W-1:0]   dref_total;
        logic [OUT_W-1:0]   pruned;
    } t_lru_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_command = 1'b0;
    logic [TAG_W-1:0]     i_address = '0;
    logic [KIND_W-1:0]    i_access_kind = '0;
    logic [BIN_W-1:0]     i_bin_index = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 o_result_strobe;
    logic                 o_hit;
    logic [BIN_W-1:0]     o_distance;
    logic                 o_evicted;
    logic [TAG_W-1:0]     o_evicted_tag;
    logic [OUT_W-1:0]     o_instr_bin_count;
    logic [OUT_W-1:0]     o_dhist_count;
    logic [OUT_W-1:0]     o_ref_total;
    logic [OUT_W-1:0]     o_dref_total;
    logic [OUT_W-1:0]     o_pruned_count;

    lru_stack_distance_histogram_unit u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // behavioral state
    logic [TAG_W-1:0]   tag_stk [DEPTH];
    int                 stk_fill;
    logic [OUT_W-1:0]   instr_hist [NUM_BINS];
    logic [OUT_W-1:0]   data_hist [NUM_BINS];
    logic [OUT_W-1:0]   total_cnt, data_cnt, prune_cnt;
    logic [LSL_W-1:0]   lsl_cfg;
    logic [LIMIT_W-1:0] limit_cfg;

    t_access_req access_q [$];
    t_lru_result lru_result_q [$];
    bit          req_taken = 1'b0;
    int          idle_pct = 0;
    int          mismatch_cnt = 0;
    int          n_results = 0, n_hits = 0, n_evicts = 0, n_reads = 0;
    int          deepest = 0, n_settings = 1;

    // stimulus generator state
    logic [TAG_W-1:0] pool_base;
    int               gen_lsl, gen_ws, last_idx;

    function automatic logic [OUT_W-1:0] sat_inc(logic [OUT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic lru_clear();
        stk_fill = 0;
        total_cnt = '0;
        data_cnt = '0;
        prune_cnt = '0;
        lsl_cfg = LSL_RESET;
        limit_cfg = LIMIT_RESET;
        for (int i = 0; i < NUM_BINS; i++) begin
            instr_hist[i] = '0;
            data_hist[i] = '0;
        end
    endtask

    task automatic stack_distance_step(input t_access_req r, output t_lru_result e);
        logic [TAG_W-1:0] tag;
        int               lim, pos, b;
        bit               is_instr;
        e = '0;
        if (r.cmd == CMD_READ) begin
            e.instr_bin = instr_hist[r.bin];
            e.data_bin = data_hist[r.bin];
        end else if (r.kind == KIND_INSTR || r.kind == KIND_DATA) begin
            is_instr = (r.kind == KIND_INSTR);
            tag = r.addr >> lsl_cfg;
            lim = (limit_cfg == 0 || limit_cfg > DEPTH) ? DEPTH : int'(limit_cfg);
            total_cnt = sat_inc(total_cnt);
            if (!is_instr)
                data_cnt = sat_inc(data_cnt);
            pos = stk_fill;
            for (int i = 0; i < stk_fill; i++) begin
                if (tag_stk[i] == tag) begin
                    pos = i;
                    break;
                end
            end
            if (pos < stk_fill) begin
                b = (pos > NUM_BINS - 1) ? NUM_BINS - 1 : pos;
                e.hit = 1'b1;
                e.distance = b[BIN_W-1:0];
                for (int i = pos; i > 0; i--)
                    tag_stk[i] = tag_stk[i-1];
                tag_stk[0] = tag;
                if (is_instr)
                    instr_hist[b] = sat_inc(instr_hist[b]);
                else
                    data_hist[b] = sat_inc(data_hist[b]);
            end else if (stk_fill + 1 > lim) begin
                e.evicted = 1'b1;
                e.evicted_tag = tag_stk[stk_fill-1];
                prune_cnt = sat_inc(prune_cnt);
                for (int i = stk_fill - 1; i > 0; i--)
                    tag_stk[i] = tag_stk[i-1];
                tag_stk[0] = tag;
            end else begin
                for (int i = stk_fill; i > 0; i--)
                    tag_stk[i] = tag_stk[i-1];
                tag_stk[0] = tag;
                stk_fill++;
            end
        end
        e.ref_total = total_cnt;
        e.dref_total = data_cnt;
        e.pruned = prune_cnt;
    endtask

    task automatic check_field(input string name, input logic [TAG_W-1:0] want,
                               input logic [TAG_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // driver: new request at the falling edge once the previous one is taken
    always @(negedge i_clk) begin : drv
        t_access_req nxt;
        if (i_rst_n && (!start || req_taken)) begin
            if (access_q.size() > 0 && !(idle_pct > 0 && $urandom_range(99) < idle_pct)) begin
                nxt = access_q.pop_front();
                start <= 1'b1;
                i_command <= nxt.cmd;
                i_address <= nxt.addr;
                i_access_kind <= nxt.kind;
                i_bin_index <= nxt.bin;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check strobed results, predict accepted requests, track config
    always @(posedge i_clk) begin : mon
        t_lru_result want;
        t_access_req r;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            if (o_result_strobe === 1'b1) begin
                if (lru_result_q.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    mismatch_cnt++;
                end else begin
                    want = lru_result_q.pop_front();
                    check_field("hit", want.hit, o_hit);
                    check_field("distance", want.distance, o_distance);
                    check_field("evicted", want.evicted, o_evicted);
                    check_field("evicted_tag", want.evicted_tag, o_evicted_tag);
                    check_field("instr_bin_count", want.instr_bin, o_instr_bin_count);
                    check_field("dhist_count", want.data_bin, o_dhist_count);
                    check_field("ref_total", want.ref_total, o_ref_total);
                    check_field("dref_total", want.dref_total, o_dref_total);
                    check_field("pruned_count", want.pruned, o_pruned_count);
                    n_results++;
                    if (want.hit) begin
                        n_hits++;
                        if (want.distance > deepest)
                            deepest = want.distance;
                    end
                    if (want.evicted)
                        n_evicts++;
                end
            end
            req_taken = start && !busy;
            if (req_taken) begin
                r.cmd = t_cmd'(i_command);
                r.addr = i_address;
                r.kind = i_access_kind;
                r.bin = i_bin_index;
                if (r.cmd == CMD_READ)
                    n_reads++;
                stack_distance_step(r, want);
                lru_result_q.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_LINE_SIZE_LOG2)
                    lsl_cfg = i_cfg_data[LSL_W-1:0];
                else
                    limit_cfg = i_cfg_data[LIMIT_W-1:0];
            end
        end
    end

    function automatic t_access_req mk(t_cmd cmd, logic [TAG_W-1:0] addr,
                                       logic [KIND_W-1:0] kind, logic [BIN_W-1:0] bin);
        t_access_req r;
        r.cmd = cmd;
        r.addr = addr;
        r.kind = kind;
        r.bin = bin;
        return r;
    endfunction

    function automatic t_access_req rand_req();
        t_access_req      r;
        int               roll, idx;
        logic [TAG_W-1:0] mask;
        roll = $urandom_range(99);
        mask = (64'd1 << gen_lsl) - 1;
        r.cmd = CMD_ACCESS;
        r.bin = BIN_W'($urandom);
        r.kind = $urandom_range(1) ? KIND_DATA : KIND_INSTR;
        r.addr = {$urandom, $urandom};
        if (roll < 8) begin
            r.cmd = CMD_READ;
            r.kind = KIND_W'($urandom);
            if ($urandom_range(1))
                r.bin = BIN_W'($urandom_range(15));
        end else if (roll < 13) begin
            r.kind = $urandom_range(1) ? KIND_RSVD : KIND_OTHER;
        end else if (roll >= 20) begin
            idx = (roll < 35) ? last_idx : $urandom_range(gen_ws - 1);
            last_idx = idx;
            r.addr = pool_base + (64'(idx) << gen_lsl) + ({$urandom, $urandom} & mask);
        end
        return r;
    endfunction

    task automatic new_pool(input int lsl, input int ws);
        gen_lsl = lsl;
        gen_ws = ws;
        last_idx = 0;
        pool_base = {$urandom, $urandom} & ~((64'd1 << lsl) - 1);
    endtask

    task automatic queue_random(input int n);
        repeat (n) access_q.push_back(rand_req());
    endtask

    // hold off until the queue is drained, every result is in and the unit is idle
    task automatic wait_idle();
        while (access_q.size() != 0 || start || lru_result_q.size() != 0 || busy)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int lsl, input int lim);
        wait_idle();
        write_reg(REG_LINE_SIZE_LOG2, CFG_DAT_W'(lsl));
        write_reg(REG_DISTANCE_LIMIT, CFG_DAT_W'(lim));
        n_settings++;
    endtask

    initial begin
        int lsl, lim;
        lru_clear();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset config, line size 64 bytes, full capacity
        idle_pct = 0;
        access_q.push_back(mk(CMD_READ, '1, KIND_RSVD, 8'd0));
        access_q.push_back(mk(CMD_READ, '0, KIND_INSTR, 8'hFF));
        access_q.push_back(mk(CMD_ACCESS, 64'h0, KIND_INSTR, 8'hFF));
        access_q.push_back(mk(CMD_ACCESS, 64'h3F, KIND_DATA, 8'h00));
        access_q.push_back(mk(CMD_ACCESS, 64'h40, KIND_OTHER, 8'h00));
        access_q.push_back(mk(CMD_ACCESS, 64'h80, KIND_RSVD, 8'h55));
        access_q.push_back(mk(CMD_ACCESS, '1, KIND_DATA, 8'hFF));
        access_q.push_back(mk(CMD_ACCESS, 64'h40, KIND_INSTR, 8'h00));
        access_q.push_back(mk(CMD_ACCESS, 64'h1, KIND_INSTR, 8'hAA));
        access_q.push_back(mk(CMD_ACCESS, 64'hFFFF_FFFF_FFFF_FFFA, KIND_DATA, 8'h00));
        access_q.push_back(mk(CMD_READ, 64'h40, KIND_DATA, 8'd2));
        access_q.push_back(mk(CMD_READ, '0, KIND_OTHER, 8'd0));
        access_q.push_back(mk(CMD_ACCESS, 64'h7F, KIND_INSTR, 8'h00));
        access_q.push_back(mk(CMD_READ, {$urandom, $urandom}, KIND_INSTR, 8'd1));
        access_q.push_back(mk(CMD_ACCESS, 64'h8000_0000_0000_0000, KIND_DATA, 8'h01));

        // small limit while the stack grows past it, widest line size
        set_regs(15, 8);
        idle_pct = 51;
        new_pool(15, 12);
        queue_random(60);

        // fill the whole stack, reuse the oldest tag, then overflow by one
        set_regs(0, 0);
        idle_pct = 0;
        new_pool(0, 300);
        for (int i = 0; i < DEPTH; i++)
            access_q.push_back(mk(CMD_ACCESS, pool_base + i, i[0] ? KIND_DATA : KIND_INSTR,
                                  BIN_W'($urandom)));
        access_q.push_back(mk(CMD_ACCESS, pool_base, KIND_DATA, 8'h00));
        access_q.push_back(mk(CMD_ACCESS, pool_base + DEPTH, KIND_INSTR, 8'h00));
        access_q.push_back(mk(CMD_READ, '0, KIND_INSTR, 8'd255));
        access_q.push_back(mk(CMD_READ, '0, KIND_DATA, 8'd0));
        wait_idle();
        idle_pct = 13;
        queue_random(150);

        // limit of one on a full stack
        set_regs(12, 1);
        idle_pct = 51;
        new_pool(12, 3);
        queue_random(80);

        // push a fresh working set, then lower the limit below the fill
        set_regs(12, 0);
        idle_pct = 0;
        new_pool(12, 40);
        for (int i = 0; i < 40; i++)
            access_q.push_back(mk(CMD_ACCESS, pool_base + (64'(i) << 12), KIND_DATA, 8'h00));
        set_regs(12, 4);
        idle_pct = 13;
        queue_random(150);

        set_regs(3, DEPTH);
        idle_pct = 51;
        new_pool(3, 200);
        queue_random(300);

        // limit field above the stack depth
        set_regs(6, 511);
        idle_pct = 0;
        new_pool(6, 270);
        queue_random(300);

        repeat (3) begin
            lsl = $urandom_range(15);
            lim = $urandom_range(2, 255);
            set_regs(lsl, lim);
            idle_pct = 13;
            new_pool(lsl, $urandom_range(8, 300));
            queue_random(100);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d results: %0d reuse hits (deepest distance %0d), %0d evictions,",
                 n_results, n_hits, deepest, n_evicts);
        $display("%0d bin reads, over %0d line size / distance limit settings",
                 n_reads, n_settings);
        if (mismatch_cnt == 0 && lru_result_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lsdh_pkg.sv
hw/rtl/lsdh_ram.sv
hw/rtl/lsdh_cell.sv
hw/rtl/lru_stack_distance_histogram_unit.sv
sim/tb_top.sv
